// ===== hw/rtl/atan2_pkg.sv =====
`timescale 1ns / 1ps

package atan2_pkg;

  // Input field and magnitude widths
  localparam int unsigned FieldW = 22;
  localparam int unsigned MagW   = FieldW - 1;

  // Largest magnitude; the most negative input saturates to it
  localparam logic [MagW-1:0] MagMax = {MagW{1'b1}};

  // Ratio t = (num << 10) / den in Q10, range 0..1024
  localparam int unsigned FracBits = 10;
  localparam int unsigned QuotW    = FracBits + 1;
  localparam int unsigned DivSteps = QuotW;
  localparam logic [QuotW-1:0] QOne = QuotW'(1 << FracBits);

  // t * (1024 - t) peaks at 2^18
  localparam int unsigned Prod1W = 2 * FracBits - 1;

  // Curvature term: 2847 * t * (1024 - t) >> 20
  localparam int unsigned CoefW  = 12;
  localparam logic [CoefW-1:0] CurveCoef = CoefW'(2847);
  localparam int unsigned Prod2W = Prod1W + CoefW;
  localparam int unsigned CorrShift = 2 * FracBits;
  localparam int unsigned CorrW  = Prod2W - CorrShift;

  // Angle in turn units, 65536 per turn
  localparam int unsigned AngleW = 16;
  localparam int unsigned LinShift = 13 - FracBits;  // 8192 * t >> 10
  localparam logic [AngleW-1:0] QuarterTurn = 16'd16384;
  localparam logic [AngleW-1:0] HalfTurn    = 16'd32768;

  // Octant bookkeeping that travels with each item
  typedef struct packed {
    logic zero;
    logic swp;
    logic xneg;
    logic yneg;
  } ctl_t;

endpackage

// ===== hw/rtl/atan2_turn_approximation_top.sv =====
`timescale 1ns / 1ps

// Angle extractor: takes a signed (y, x) pair and returns atan2(y, x) as an
// unsigned 16-bit angle where 65536 is one full turn, counterclockwise from
// +x; (0, 0) gives 0 and -2097152 is treated as -2097151. The block takes one
// pair every cycle while in_stall_o is low and is fully pipelined, with 17
// register stages (one input stage, magnitude, swap, eleven restoring divide
// stages that each resolve one bit of the Q10 ratio, two multiply stages and
// the octant fixup). A one-entry skid buffer sits in front so that in_stall_o
// comes from a register; output stalls freeze the whole pipe, and no transfer
// is lost or repeated.
module atan2_turn_approximation_top
  import atan2_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [FieldW-1:0] y_value_i,
  input  logic signed [FieldW-1:0] x_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic        [AngleW-1:0] angle_turns_o
);

  // Pipe advances whenever the output register is free to move
  logic en;
  logic in_acc;

  assign en     = !(out_valid_o && out_stall_i);
  assign in_acc = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------
  // Skid buffer and input stage
  // ---------------------------------------------------------------------
  logic                     sk_v_q;
  logic signed [FieldW-1:0] sk_y_q, sk_x_q;
  logic                     p0_v_q;
  logic signed [FieldW-1:0] p0_y_q, p0_x_q;

  assign in_stall_o = sk_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_v_q <= 1'b0;
      p0_v_q <= 1'b0;
    end else if (en) begin
      // Drain the skid first; the input is stalled while it is full
      p0_v_q <= sk_v_q || in_valid_i;
      sk_v_q <= 1'b0;
    end else if (in_acc) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_y_q <= sk_v_q ? sk_y_q : y_value_i;
      p0_x_q <= sk_v_q ? sk_x_q : x_value_i;
    end else if (in_acc) begin
      sk_y_q <= y_value_i;
      sk_x_q <= x_value_i;
    end
  end

  // ---------------------------------------------------------------------
  // Magnitudes with saturation of the most negative code
  // ---------------------------------------------------------------------
  logic [FieldW-1:0] y_abs, x_abs;
  logic [MagW-1:0]   y_mag_d, x_mag_d;
  ctl_t              p1_ctl_d;

  always_comb begin
    y_abs = p0_y_q[FieldW-1] ? (FieldW'(0) - p0_y_q) : p0_y_q;
    x_abs = p0_x_q[FieldW-1] ? (FieldW'(0) - p0_x_q) : p0_x_q;
    y_mag_d = y_abs[FieldW-1] ? MagMax : y_abs[MagW-1:0];
    x_mag_d = x_abs[FieldW-1] ? MagMax : x_abs[MagW-1:0];
    p1_ctl_d.zero = (p0_y_q == '0) && (p0_x_q == '0);
    p1_ctl_d.swp  = 1'b0;
    p1_ctl_d.xneg = p0_x_q[FieldW-1];
    p1_ctl_d.yneg = p0_y_q[FieldW-1];
  end

  logic            p1_v_q;
  logic [MagW-1:0] p1_ymag_q, p1_xmag_q;
  ctl_t            p1_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= p0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_ymag_q <= y_mag_d;
      p1_xmag_q <= x_mag_d;
      p1_ctl_q  <= p1_ctl_d;
    end
  end

  // ---------------------------------------------------------------------
  // Order magnitudes: smaller one becomes the numerator
  // ---------------------------------------------------------------------
  logic            swp_d;
  ctl_t            p2_ctl_d;
  logic            p2_v_q;
  logic [MagW-1:0] num_q, den_q;
  ctl_t            p2_ctl_q;

  assign swp_d = p1_ymag_q > p1_xmag_q;

  always_comb begin
    p2_ctl_d     = p1_ctl_q;
    p2_ctl_d.swp = swp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (en) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q    <= swp_d ? p1_xmag_q : p1_ymag_q;
      den_q    <= swp_d ? p1_ymag_q : p1_xmag_q;
      p2_ctl_q <= p2_ctl_d;
    end
  end

  // ---------------------------------------------------------------------
  // Restoring divide, one quotient bit per stage, MSB first.
  // The remainder stays below den, so the shifted value fits MagW+1 bits.
  // ---------------------------------------------------------------------
  logic             dv_q   [DivSteps];
  logic [MagW-1:0]  drem_q [DivSteps];
  logic [MagW-1:0]  dden_q [DivSteps];
  logic [QuotW-1:0] dquo_q [DivSteps];
  ctl_t             dctl_q [DivSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic             v_in;
    logic [MagW:0]    r_in;
    logic [MagW-1:0]  d_in;
    logic [QuotW-1:0] q_in;
    ctl_t             c_in;
    logic             ge;
    logic [MagW:0]    r_sub;

    if (j == 0) begin : g_first
      assign v_in = p2_v_q;
      assign r_in = {1'b0, num_q};
      assign d_in = den_q;
      assign q_in = '0;
      assign c_in = p2_ctl_q;
    end else begin : g_next
      assign v_in = dv_q[j-1];
      assign r_in = {drem_q[j-1], 1'b0};
      assign d_in = dden_q[j-1];
      assign q_in = dquo_q[j-1];
      assign c_in = dctl_q[j-1];
    end

    assign r_sub = r_in - {1'b0, d_in};
    assign ge    = r_in >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en) begin
        dv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        drem_q[j] <= ge ? r_sub[MagW-1:0] : r_in[MagW-1:0];
        dden_q[j] <= d_in;
        dquo_q[j] <= {q_in[QuotW-2:0], ge};
        dctl_q[j] <= c_in;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Polynomial: t * (1024 - t), then times the curvature coefficient
  // ---------------------------------------------------------------------
  logic [QuotW-1:0] t_last;
  logic [QuotW-1:0] t_comp;
  logic [2*QuotW-1:0] prod1_full;

  assign t_last     = dquo_q[DivSteps-1];
  assign t_comp     = QOne - t_last;
  assign prod1_full = t_last * t_comp;

  logic              m1_v_q;
  logic [QuotW-1:0]  m1_t_q;
  logic [Prod1W-1:0] m1_prod_q;
  ctl_t              m1_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= dv_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_t_q    <= t_last;
      m1_prod_q <= prod1_full[Prod1W-1:0];
      m1_ctl_q  <= dctl_q[DivSteps-1];
    end
  end

  logic [Prod2W-1:0] prod2;

  assign prod2 = m1_prod_q * CurveCoef;

  logic             m2_v_q;
  logic [QuotW-1:0] m2_t_q;
  logic [CorrW-1:0] m2_corr_q;
  ctl_t             m2_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (en) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_t_q    <= m1_t_q;
      m2_corr_q <= prod2[Prod2W-1:CorrShift];
      m2_ctl_q  <= m1_ctl_q;
    end
  end

  // ---------------------------------------------------------------------
  // Octant fixup, all modulo one turn
  // ---------------------------------------------------------------------
  logic [AngleW-1:0] a_oct, a_swp, a_x, a_y, angle_d;

  always_comb begin
    a_oct   = AngleW'({m2_t_q, LinShift'(0)}) + AngleW'(m2_corr_q);
    a_swp   = m2_ctl_q.swp  ? (QuarterTurn - a_oct) : a_oct;
    a_x     = m2_ctl_q.xneg ? (HalfTurn - a_swp)    : a_swp;
    a_y     = m2_ctl_q.yneg ? (AngleW'(0) - a_x)    : a_x;
    angle_d = m2_ctl_q.zero ? '0 : a_y;
  end

  logic              out_v_q;
  logic [AngleW-1:0] angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= angle_d;
    end
  end

  assign out_valid_o   = out_v_q;
  assign angle_turns_o = angle_q;

endmodule
